// ----- rtl/core/sector_bitmap_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Sector bitmap allocator assertion macros
// Concurrent checks on clock, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef SECTOR_BITMAP_ALLOCATOR_ASSERT_SVH
`define SECTOR_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SBA_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SBA_CHECK_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SBA_CHECK(lbl, prop, msg)
`define SBA_CHECK_RST(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/sba_pkg.sv -----
// ----------------------------------------------------------------------------
// Sector bitmap allocator package
// Command codes, register indexes, geometry constants and byte popcount.
// ----------------------------------------------------------------------------
package sba_pkg;

   localparam logic [2:0] CMD_ALLOC  = 3'd0;
   localparam logic [2:0] CMD_FREE   = 3'd1;
   localparam logic [2:0] CMD_MARK   = 3'd2;
   localparam logic [2:0] CMD_QUERY  = 3'd3;
   localparam logic [2:0] CMD_COUNT  = 3'd4;
   localparam logic [2:0] CMD_FORMAT = 3'd5;

   localparam logic CSR_SIDE_COUNT  = 1'b0;
   localparam logic CSR_TRACK_COUNT = 1'b1;

   localparam logic [1:0] SIDE_RESET  = 2'd1;
   localparam logic [6:0] TRACK_RESET = 7'd40;
   localparam logic [6:0] TRACK_SPLIT = 7'd40;

   localparam logic [7:0] FULL_BYTE  = 8'hFF;
   localparam logic [3:0] NIBBLE_MSK = 4'hF;

   localparam logic [7:0]  SECTORS_PER_TRACK = 8'd18;
   localparam logic [12:0] FMT_T16_ONE = 13'd288;
   localparam logic [12:0] FMT_T20_ONE = 13'd360;
   localparam logic [12:0] FMT_T16_TWO = 13'd576;
   localparam logic [12:0] FMT_T20_TWO = 13'd720;

   localparam logic [12:0] FREE_SAT = 13'd4095;

   localparam logic [3:0] NIBBLE_ONES [16] = '{
      4'd0, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd2, 4'd3,
      4'd1, 4'd2, 4'd2, 4'd3, 4'd2, 4'd3, 4'd3, 4'd4
   };

   function automatic logic [3:0] byte_ones(input logic [7:0] b);
      logic [3:0] lo;
      logic [3:0] hi;
      lo = b[3:0] & NIBBLE_MSK;
      hi = b[7:4];
      return NIBBLE_ONES[lo] + NIBBLE_ONES[hi];
   endfunction

endpackage

// ----- rtl/core/sba_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// Sector bitmap RAM
// Single-port byte memory, registered read every cycle at the shared address.
// ----------------------------------------------------------------------------
module sba_bitmap_ram #(
   parameter int DEPTH = 360,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rd_data = rdata_ff;

endmodule

// ----- rtl/core/sector_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// Sector bitmap allocator
// Free-sector bitmap with allocate, free, mark, query, count and format.
// Allocate first counts the free total and is refused when that is short;
//   it then scans for a run of fully free bytes and marks the run used.
//   Format fills the store, then marks the directory tracks used.
// One beat at a time; the next beat is taken the cycle after the result loads.
// After reset a clearing pass over all PAGE_BYTES*PAGE_COUNT bytes runs first.
// ----------------------------------------------------------------------------
`include "sector_bitmap_allocator_assert.svh"

module sector_bitmap_allocator #(
   parameter int PAGE_BYTES = 180,
   parameter int PAGE_COUNT = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [11:0] req_lsn,
   input  logic [7:0]  req_sector_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [11:0] rsp_start_lsn,
   output logic        rsp_is_free,
   output logic [11:0] rsp_free_sectors,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int STORE_BYTES = PAGE_BYTES * PAGE_COUNT;
   localparam int TOTAL       = STORE_BYTES * 8;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int PW          = $clog2(STORE_BYTES + 1);
   localparam bit TWO_PAGES   = (PAGE_COUNT > 1);

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_CNT      = 9'b000000100,
      ST_SCAN     = 9'b000001000,
      ST_ALLOC_WR = 9'b000010000,
      ST_RMW_RD   = 9'b000100000,
      ST_RMW_WR   = 9'b001000000,
      ST_FILL     = 9'b010000000,
      ST_DONE     = 9'b100000000
   } sba_state_type;

   sba_state_type st_ff, st_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [12:0]   sec_ff, sec_in;
   logic [7:0]    rem_ff, rem_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic [5:0]    need_ff, need_in;
   logic [5:0]    run_ff, run_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] daddr_ff;
   logic          pend_ff, pend_in;
   logic          fmt_ph_ff, fmt_ph_in;
   logic          ok_ff, ok_in;
   logic [11:0]   start_ff, start_in;
   logic          isfree_ff, isfree_in;
   logic [12:0]   acc_ff, acc_in;
   logic [1:0]    side_ff;
   logic [6:0]    track_ff;
   logic          rsp_valid_ff;
   logic          rsp_ok_ff;
   logic [11:0]   rsp_start_ff;
   logic          rsp_isfree_ff;
   logic [11:0]   rsp_free_ff;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   logic          req_accept;
   logic          rsp_load;
   logic          two_sides;
   logic          wide_disk;
   logic [PW-1:0] cnt_limit;
   logic [PW-1:0] scan_limit;
   logic          issue;
   logic          boundary;
   logic [5:0]    run_next;
   logic [AW-1:0] start_byte;
   logic [7:0]    fill_val;
   logic [7:0]    bit_mask;
   logic [11:0]   sat_free;

   assign two_sides  = side_ff[1];
   assign wide_disk  = two_sides && (track_ff > sba_pkg::TRACK_SPLIT);
   assign cnt_limit  = (two_sides && TWO_PAGES) ? PW'(2 * PAGE_BYTES) : PW'(PAGE_BYTES);
   assign scan_limit = (wide_disk && TWO_PAGES) ? PW'(2 * PAGE_BYTES) : PW'(PAGE_BYTES);
   assign boundary   = ({1'b0, daddr_ff} == (AW + 1)'(PAGE_BYTES));
   assign start_byte = daddr_ff - AW'(need_ff) + AW'(1);
   assign bit_mask   = 8'b1 << sec_ff[2:0];
   assign sat_free   = (acc_ff > sba_pkg::FREE_SAT) ? 12'hFFF : acc_ff[11:0];

   assign req_stall  = (st_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (st_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (ptr_ff < PW'(PAGE_BYTES)) begin
         if (!two_sides && (track_ff <= sba_pkg::TRACK_SPLIT)
             && (ptr_ff >= PW'(PAGE_BYTES / 2))) begin
            fill_val = 8'h00;
         end else begin
            fill_val = sba_pkg::FULL_BYTE;
         end
      end else begin
         fill_val = wide_disk ? sba_pkg::FULL_BYTE : 8'h00;
      end
   end

   always_comb begin
      st_in     = st_ff;
      cmd_in    = cmd_ff;
      sec_in    = sec_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      need_in   = need_ff;
      run_in    = run_ff;
      ptr_in    = ptr_ff;
      pend_in   = 1'b0;
      fmt_ph_in = fmt_ph_ff;
      ok_in     = ok_ff;
      start_in  = start_ff;
      isfree_in = isfree_ff;
      acc_in    = acc_ff;
      ram_we    = 1'b0;
      ram_addr  = ptr_ff[AW-1:0];
      ram_wdata = 8'h00;
      issue     = 1'b0;
      run_next  = 6'd0;
      case (st_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ptr_in = ptr_ff + PW'(1);
            if (ptr_ff == PW'(STORE_BYTES - 1)) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_command;
               sec_in    = {1'b0, req_lsn};
               rem_in    = req_sector_count;
               cnt_in    = req_sector_count;
               need_in   = 6'((9'(req_sector_count) + 9'd7) >> 3);
               run_in    = 6'd0;
               ptr_in    = '0;
               fmt_ph_in = 1'b0;
               ok_in     = 1'b1;
               start_in  = 12'd0;
               isfree_in = 1'b0;
               acc_in    = 13'd0;
               case (req_command)
                  sba_pkg::CMD_ALLOC: begin
                     ok_in = 1'b0;
                     st_in = (req_sector_count == 8'd0) ? ST_DONE : ST_CNT;
                  end
                  sba_pkg::CMD_FREE,
                  sba_pkg::CMD_MARK: begin
                     st_in = ST_RMW_RD;
                  end
                  sba_pkg::CMD_QUERY: begin
                     rem_in = 8'd1;
                     st_in  = ST_RMW_RD;
                  end
                  sba_pkg::CMD_COUNT: begin
                     st_in = ST_CNT;
                  end
                  sba_pkg::CMD_FORMAT: begin
                     st_in = ST_FILL;
                  end
                  default: begin
                     ok_in = 1'b0;
                     st_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CNT: begin
            issue = (ptr_ff < cnt_limit);
            if (issue) begin
               ptr_in = ptr_ff + PW'(1);
            end
            pend_in = issue;
            if (pend_ff) begin
               acc_in = acc_ff + 13'(sba_pkg::byte_ones(ram_rdata));
            end
            if (!issue && !pend_ff) begin
               if (cmd_ff == sba_pkg::CMD_ALLOC) begin
                  if ({5'b0, cnt_ff} > acc_ff) begin
                     st_in = ST_DONE;
                  end else begin
                     ptr_in = '0;
                     run_in = 6'd0;
                     st_in  = ST_SCAN;
                  end
               end else begin
                  st_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            issue = (ptr_ff < scan_limit);
            if (issue) begin
               ptr_in = ptr_ff + PW'(1);
            end
            pend_in = issue;
            if (pend_ff) begin
               if (ram_rdata == sba_pkg::FULL_BYTE) begin
                  run_next = boundary ? 6'd1 : run_ff + 6'd1;
               end
               run_in = run_next;
               if (run_next == need_ff) begin
                  ptr_in   = PW'(start_byte);
                  start_in = 12'({start_byte, 3'b000});
                  rem_in   = cnt_ff;
                  pend_in  = 1'b0;
                  st_in    = ST_ALLOC_WR;
               end
            end
            if (!issue && !pend_ff) begin
               st_in = ST_DONE;
            end
         end
         ST_ALLOC_WR: begin
            ram_we = 1'b1;
            ptr_in = ptr_ff + PW'(1);
            if (rem_ff >= 8'd8) begin
               ram_wdata = 8'h00;
               rem_in    = rem_ff - 8'd8;
            end else begin
               ram_wdata = sba_pkg::FULL_BYTE << rem_ff[2:0];
               rem_in    = 8'd0;
            end
            if (rem_in == 8'd0) begin
               ok_in = 1'b1;
               st_in = ST_DONE;
            end
         end
         ST_RMW_RD: begin
            ram_addr = sec_ff[AW+2:3];
            if (rem_ff == 8'd0) begin
               if ((cmd_ff == sba_pkg::CMD_FORMAT) && !fmt_ph_ff) begin
                  sec_in    = two_sides ? sba_pkg::FMT_T20_TWO : sba_pkg::FMT_T20_ONE;
                  rem_in    = sba_pkg::SECTORS_PER_TRACK;
                  fmt_ph_in = 1'b1;
               end else begin
                  st_in = ST_DONE;
               end
            end else if (sec_ff >= 13'(TOTAL)) begin
               sec_in = sec_ff + 13'd1;
               rem_in = rem_ff - 8'd1;
            end else begin
               st_in = ST_RMW_WR;
            end
         end
         ST_RMW_WR: begin
            ram_addr = sec_ff[AW+2:3];
            ram_we   = (cmd_ff != sba_pkg::CMD_QUERY);
            if (cmd_ff == sba_pkg::CMD_FREE) begin
               ram_wdata = ram_rdata | bit_mask;
            end else begin
               ram_wdata = ram_rdata & ~bit_mask;
            end
            if (cmd_ff == sba_pkg::CMD_QUERY) begin
               isfree_in = ram_rdata[sec_ff[2:0]];
            end
            sec_in = sec_ff + 13'd1;
            rem_in = rem_ff - 8'd1;
            st_in  = ST_RMW_RD;
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_wdata = fill_val;
            ptr_in    = ptr_ff + PW'(1);
            if (ptr_ff == PW'(STORE_BYTES - 1)) begin
               sec_in    = two_sides ? sba_pkg::FMT_T16_TWO : sba_pkg::FMT_T16_ONE;
               rem_in    = sba_pkg::SECTORS_PER_TRACK;
               fmt_ph_in = 1'b0;
               st_in     = ST_RMW_RD;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_CLEAR;
         ptr_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         ptr_ff  <= ptr_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      sec_ff    <= sec_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      need_ff   <= need_in;
      run_ff    <= run_in;
      daddr_ff  <= ptr_ff[AW-1:0];
      fmt_ph_ff <= fmt_ph_in;
      ok_ff     <= ok_in;
      start_ff  <= start_in;
      isfree_ff <= isfree_in;
      acc_ff    <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= sba_pkg::SIDE_RESET;
         track_ff <= sba_pkg::TRACK_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sba_pkg::CSR_SIDE_COUNT: begin
               side_ff <= csr_wdata[1:0];
            end
            sba_pkg::CSR_TRACK_COUNT: begin
               track_ff <= csr_wdata;
            end
            default: begin
               side_ff <= side_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff     <= ok_ff;
         rsp_start_ff  <= start_ff;
         rsp_isfree_ff <= isfree_ff;
         rsp_free_ff   <= (cmd_ff == sba_pkg::CMD_COUNT) ? sat_free : 12'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_start_lsn    = rsp_start_ff;
   assign rsp_is_free      = rsp_isfree_ff;
   assign rsp_free_sectors = rsp_free_ff;

   sba_bitmap_ram #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   `SBA_CHECK(a_accept_leaves_idle, req_accept |=> st_ff != ST_IDLE, "beat accepted but idle")
   `SBA_CHECK(a_fail_no_start, rsp_valid && !rsp_ok |-> rsp_start_lsn == 12'd0, "start on fail")
   `SBA_CHECK(a_count_needs_ok, rsp_valid && rsp_free_sectors != 12'd0 |-> rsp_ok, "count not ok")
   `SBA_CHECK(a_done_waits, st_ff == ST_DONE && rsp_valid && rsp_stall |=> st_ff == ST_DONE, "rsp overrun")
   `SBA_CHECK_RST(a_reset_clears, $past(reset) && !reset |-> st_ff == ST_CLEAR, "no clear pass")

endmodule

// ----- test/sector_bitmap_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// Sector bitmap allocator testbench
// Drives command beats against a behavioral copy of the free-sector bitmap
// and checks every result beat field by field. A short table of directed
// beats comes first. Random phases follow, each under its own disk geometry.
// Both sides idle at random, and the result side holds off at length.
// ----------------------------------------------------------------------------
module sector_bitmap_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGE_BYTES     = 180;
   localparam int PAGE_COUNT     = 2;
   localparam int STORE_BYTES    = PAGE_BYTES * PAGE_COUNT;
   localparam int TOTAL_SECTORS  = STORE_BYTES * 8;
   localparam int DIR_TRACK_LO   = 16;
   localparam int DIR_TRACK_HI   = 20;
   localparam int DIR_TRACK_STEP = 4;
   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 500;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int PHASES         = 8;
   localparam int PHASE_BEATS    = 65;
   localparam int DIR_ROWS       = 26;

   localparam logic [2:0] CMD_BAD_A = 3'd6;
   localparam logic [2:0] CMD_BAD_B = 3'd7;

   typedef struct packed {
      logic        ok;
      logic [11:0] start_lsn;
      logic        is_free;
      logic [11:0] free_sectors;
   } result_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [11:0] lsn;
      logic [7:0]  cnt;
      logic        typed;
      logic        w_ok;
      logic [11:0] w_start;
      logic        w_is_free;
      logic [11:0] w_free;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [11:0] req_lsn = '0;
   logic [7:0]  req_sector_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic [11:0] rsp_start_lsn;
   logic        rsp_is_free;
   logic [11:0] rsp_free_sectors;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = sba_pkg::CSR_SIDE_COUNT;
   logic [6:0]  csr_wdata = '0;

   sector_bitmap_allocator #(
      .PAGE_BYTES(PAGE_BYTES),
      .PAGE_COUNT(PAGE_COUNT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_lsn          (req_lsn),
      .req_sector_count (req_sector_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_start_lsn    (rsp_start_lsn),
      .rsp_is_free      (rsp_is_free),
      .rsp_free_sectors (rsp_free_sectors),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // behavioral bitmap and geometry
   logic [7:0]  bitmap_copy [STORE_BYTES];
   logic [1:0]  sides_cfg  = sba_pkg::SIDE_RESET;
   logic [6:0]  tracks_cfg = sba_pkg::TRACK_RESET;

   result_type  awaited_results [$];
   logic [11:0] granted_runs [$];
   int          mismatches = 0;
   int          beat_no = 0;
   int          stuck_cycles = 0;
   bit          calm_phase = 1'b0;
   bit          hold_off_req = 1'b0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{sba_pkg::CMD_COUNT,  12'd0,    8'd0,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_QUERY,  12'd0,    8'd0,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_ALLOC,  12'd0,    8'd1,   1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{CMD_BAD_A,           12'd4095, 8'd255, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{CMD_BAD_B,           12'd0,    8'd0,   1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_FREE,   12'd1432, 8'd8,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_ALLOC,  12'd0,    8'd8,   1'b1, 1'b1, 12'd1432, 1'b0, 12'd0},
      '{sba_pkg::CMD_QUERY,  12'd1432, 8'd0,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_FREE,   12'd1440, 8'd8,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_ALLOC,  12'd0,    8'd8,   1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_FORMAT, 12'd0,    8'd0,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_COUNT,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_ALLOC,  12'd0,    8'd0,   1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_ALLOC,  12'd0,    8'd255, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_ALLOC,  12'd0,    8'd1,   1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_QUERY,  12'd2879, 8'd0,   1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_QUERY,  12'd2880, 8'd0,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_QUERY,  12'd4095, 8'd0,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_MARK,   12'd0,    8'd0,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_FREE,   12'd2870, 8'd255, 1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_QUERY,  12'd2875, 8'd0,   1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_MARK,   12'd100,  8'd255, 1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_FREE,   12'd0,    8'd255, 1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_COUNT,  12'd0,    8'd0,   1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_ALLOC,  12'd0,    8'd200, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{sba_pkg::CMD_FORMAT, 12'd0,    8'd0,   1'b1, 1'b1, 12'd0,    1'b0, 12'd0}
   };

   logic [1:0] phase_side  [PHASES] = '{2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1};
   logic [6:0] phase_track [PHASES] = '{7'd40, 7'd80, 7'd1, 7'd41, 7'd40, 7'd80, 7'd40, 7'd80};

   function automatic int unsigned sides_in_use();
      if (sides_cfg == 2'd0) return 1;
      if (sides_cfg == 2'd3) return 2;
      return 32'(sides_cfg);
   endfunction

   function automatic int unsigned clamp_pages(int unsigned n);
      return (n > PAGE_COUNT) ? PAGE_COUNT : n;
   endfunction

   function automatic void set_sector(int unsigned lsn, bit free_it);
      if (lsn >= TOTAL_SECTORS) return;
      bitmap_copy[lsn[11:3]][lsn[2:0]] = free_it;
   endfunction

   function automatic int unsigned free_total();
      int unsigned total;
      int unsigned i;
      total = 0;
      for (i = 0; i < clamp_pages(sides_in_use()) * PAGE_BYTES; i++)
         total += $countones(bitmap_copy[i]);
      return total;
   endfunction

   function automatic void format_bitmap();
      int unsigned sides;
      int unsigned i;
      int unsigned t;
      int unsigned s;
      sides = sides_in_use();
      for (i = 0; i < PAGE_BYTES; i++) bitmap_copy[i] = sba_pkg::FULL_BYTE;
      if (sides == 1 && tracks_cfg <= sba_pkg::TRACK_SPLIT)
         for (i = PAGE_BYTES / 2; i < PAGE_BYTES; i++) bitmap_copy[i] = 8'h00;
      for (i = PAGE_BYTES; i < STORE_BYTES; i++)
         bitmap_copy[i] = (sides == 2 && tracks_cfg > sba_pkg::TRACK_SPLIT) ?
                          sba_pkg::FULL_BYTE : 8'h00;
      // directory tracks on side 0
      for (t = DIR_TRACK_LO; t <= DIR_TRACK_HI; t += DIR_TRACK_STEP)
         for (s = 0; s < sba_pkg::SECTORS_PER_TRACK; s++)
            set_sector(t * sba_pkg::SECTORS_PER_TRACK * sides + s, 1'b0);
   endfunction

   function automatic bit claim_run(int unsigned cnt, output int unsigned first);
      int unsigned need;
      int unsigned pages;
      int unsigned p;
      int unsigned b;
      int unsigned k;
      bit          fit;
      first = 0;
      if (cnt == 0 || cnt > free_total()) return 1'b0;
      need = (cnt + 7) / 8;
      pages = clamp_pages((tracks_cfg > sba_pkg::TRACK_SPLIT && sides_in_use() > 1) ? 2 : 1);
      for (p = 0; p < pages; p++) begin
         for (b = 0; b + need <= PAGE_BYTES; b++) begin
            fit = 1'b1;
            for (k = 0; k < need; k++)
               if (bitmap_copy[p * PAGE_BYTES + b + k] != sba_pkg::FULL_BYTE) fit = 1'b0;
            if (fit) begin
               first = (p * PAGE_BYTES + b) * 8;
               for (k = 0; k < cnt; k++) set_sector(first + k, 1'b0);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic result_type bitmap_step(logic [2:0] cmd, logic [11:0] lsn,
                                              logic [7:0] cnt);
      result_type  r;
      int unsigned first;
      int unsigned k;
      int unsigned tot;
      r = '0;
      case (cmd)
         sba_pkg::CMD_ALLOC: begin
            if (claim_run(32'(cnt), first)) begin
               r.ok = 1'b1;
               r.start_lsn = first[11:0];
               granted_runs = {granted_runs, first[11:0]};
               if (granted_runs.size() > 32) void'(granted_runs.pop_front());
            end
         end
         sba_pkg::CMD_FREE, sba_pkg::CMD_MARK: begin
            for (k = 0; k < cnt; k++) set_sector(32'(lsn) + k, cmd == sba_pkg::CMD_FREE);
            r.ok = 1'b1;
         end
         sba_pkg::CMD_QUERY: begin
            if (lsn < TOTAL_SECTORS) r.is_free = bitmap_copy[lsn[11:3]][lsn[2:0]];
            r.ok = 1'b1;
         end
         sba_pkg::CMD_COUNT: begin
            tot = free_total();
            if (tot > sba_pkg::FREE_SAT) tot = 32'(sba_pkg::FREE_SAT);
            r.free_sectors = tot[11:0];
            r.ok = 1'b1;
         end
         sba_pkg::CMD_FORMAT: begin
            format_bitmap();
            r.ok = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // mostly short gaps, a few long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 60);
   endfunction

   task automatic note_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch on result %0d, %s: got %0d, want %0d", beat_no, what, got, want);
      mismatches++;
   endtask

   task automatic send_cmd(input logic [2:0] cmd, input logic [11:0] lsn,
                           input logic [7:0] cnt, input bit typed, input result_type want);
      result_type  pred;
      int unsigned gap;
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_lsn          <= lsn;
      req_sector_count <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = bitmap_step(cmd, lsn, cnt);
      awaited_results = {awaited_results, (typed ? want : pred)};
      @(negedge clock);
      gap = calm_phase ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic program_geometry(input logic [1:0] side, input logic [6:0] track);
      csr_wr_en <= 1'b1;
      csr_index <= sba_pkg::CSR_SIDE_COUNT;
      csr_wdata <= {5'd0, side};
      @(negedge clock);
      csr_index <= sba_pkg::CSR_TRACK_COUNT;
      csr_wdata <= track;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sides_cfg  = side;
      tracks_cfg = track;
      @(negedge clock);
   endtask

   task automatic pick_request(output logic [2:0] cmd, output logic [11:0] lsn,
                               output logic [7:0] cnt);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      lsn = 12'($urandom_range(0, TOTAL_SECTORS - 1));
      if ($urandom_range(0, 9) == 0) lsn = 12'($urandom_range(0, 4095));
      cnt = 8'($urandom_range(0, 255));
      if (sel < 30) begin
         cmd = sba_pkg::CMD_ALLOC;
         if ($urandom_range(0, 9) > 1) cnt = 8'($urandom_range(1, 40));
      end else if (sel < 45) begin
         cmd = sba_pkg::CMD_FREE;
         if (granted_runs.size() != 0 && $urandom_range(0, 1) == 1) begin
            lsn = granted_runs[$urandom_range(0, granted_runs.size() - 1)];
            cnt = 8'($urandom_range(1, 64));
         end
      end else if (sel < 60) begin
         cmd = sba_pkg::CMD_MARK;
      end else if (sel < 75) begin
         cmd = sba_pkg::CMD_QUERY;
      end else if (sel < 85) begin
         cmd = sba_pkg::CMD_COUNT;
      end else if (sel < 90) begin
         cmd = sba_pkg::CMD_FORMAT;
      end else if (sel < 94) begin
         cmd = ($urandom_range(0, 1) == 1) ? CMD_BAD_A : CMD_BAD_B;
      end else begin
         // runs near or past the end of the store
         cmd = ($urandom_range(0, 1) == 1) ? sba_pkg::CMD_FREE : sba_pkg::CMD_MARK;
         lsn = 12'($urandom_range(2800, 4095));
      end
   endtask

   // result side: random stalls plus the long hold-off on request
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            stall_left = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm_phase) stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beat_no++;
         if (awaited_results.size() == 0) begin
            note_mismatch("beat with nothing awaited", 1, 0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_ok !== want.ok) note_mismatch("ok", 32'(rsp_ok), 32'(want.ok));
            if (rsp_start_lsn !== want.start_lsn)
               note_mismatch("start_lsn", 32'(rsp_start_lsn), 32'(want.start_lsn));
            if (rsp_is_free !== want.is_free)
               note_mismatch("is_free", 32'(rsp_is_free), 32'(want.is_free));
            if (rsp_free_sectors !== want.free_sectors)
               note_mismatch("free_sectors", 32'(rsp_free_sectors), 32'(want.free_sectors));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      logic [2:0]  cmd;
      logic [11:0] lsn;
      logic [7:0]  cnt;
      logic [6:0]  track;
      result_type  want;
      int          i;
      int          ph;
      int          n;
      for (i = 0; i < STORE_BYTES; i++) bitmap_copy[i] = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         want = '{dir_rows[i].w_ok, dir_rows[i].w_start, dir_rows[i].w_is_free,
                  dir_rows[i].w_free};
         send_cmd(dir_rows[i].cmd, dir_rows[i].lsn, dir_rows[i].cnt, dir_rows[i].typed, want);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         track = (ph == 6) ? 7'($urandom_range(1, 80)) : phase_track[ph];
         program_geometry(phase_side[ph], track);
         calm_phase = (ph == 2 || ph == 5);
         send_cmd(sba_pkg::CMD_FORMAT, 12'd0, 8'd0, 1'b0, '0);
         for (n = 0; n < PHASE_BEATS; n++) begin
            if ((ph == 1 || ph == 4) && n == 20) hold_off_req = 1'b1;
            pick_request(cmd, lsn, cnt);
            send_cmd(cmd, lsn, cnt, 1'b0, '0);
         end
      end

      calm_phase = 1'b0;
      wait_drained();
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
